>>> design/bpfa_pkg.sv
`default_nettype none

package bpfa_pkg;

	// operation codes
	typedef enum logic [1:0] {
		OP_ALLOC          = 2'd0,
		OP_FREE_PAGE      = 2'd1,
		OP_FREE_REGION    = 2'd2,
		OP_RESERVE_REGION = 2'd3
	} op_t;

	// controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC,
		ST_BOUND,
		ST_SCAN,
		ST_POST
	} state_t;

	localparam int WORD_BITS = 32;
	localparam int BIT_IDX_W = 5;
	localparam logic [BIT_IDX_W-1:0] BIT_IDX_MAX = 5'd31;
	localparam int ADDR_W    = 24;
	localparam int BASE_W    = 32;
	localparam int END_W     = 34;
	localparam int CFG_W     = 10;
	localparam logic [CFG_W-1:0] CFG_RESET = 10'd512;
	// eight pages per bitmap byte
	localparam int BYTE_SHIFT = 3;

	typedef struct packed {
		op_t                op;
		logic [BASE_W-1:0]  region_base;
		logic [BASE_W-1:0]  region_length;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  page_address;
		logic               status;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic calc;
		logic bound;
		logic scan;
		logic post;
		logic clear;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic empty;
		logic scan_done;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

>>> design/bpfa_ctrl.sv
`default_nettype none

module bpfa_ctrl
	import bpfa_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_CALC;
			end
			ST_CALC: begin
				state_d = ST_BOUND;
			end
			ST_BOUND: begin
				state_d = sts.empty ? ST_POST : ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_done) state_d = ST_POST;
			end
			ST_POST: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: cmd.clear = 1'b1;
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_CALC:  cmd.calc = 1'b1;
			ST_BOUND: cmd.bound = 1'b1;
			ST_SCAN:  cmd.scan = 1'b1;
			ST_POST:  cmd.post = sts.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> design/bpfa_datapath.sv
`default_nettype none

module bpfa_datapath
	import bpfa_pkg::*;
#(
	parameter int PAGE_BYTES = 4096,
	parameter int NUM_PAGES  = 4096
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CFG_W-1:0] cfg_wr_data,
	input  wire in_item_t         in_data,
	input  wire cmd_t             cmd,
	output sts_t                  sts,
	input  wire logic             out_stall,
	output logic                  out_valid,
	output out_item_t             out_data
);

	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int MAP_WORDS  = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WI_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int PW         = WI_W + BIT_IDX_W;
	localparam int FA_W       = PW + PAGE_SHIFT + ADDR_W;
	localparam logic [END_W-1:0] NUM_PAGES_E = END_W'(NUM_PAGES);
	localparam logic [WI_W-1:0]  LAST_WORD   = WI_W'(MAP_WORDS - 1);

	// configuration
	logic [CFG_W-1:0] bitmap_bytes_q;

	// captured transaction
	op_t               op_q;
	logic [BASE_W-1:0] base_q;
	logic [BASE_W-1:0] len_q;

	// page bounds
	logic [BASE_W-1:0]    first_q;
	logic [END_W-1:0]     stop_raw_q;
	logic [WI_W-1:0]      first_word_q;
	logic [WI_W-1:0]      last_word_q;
	logic [BIT_IDX_W-1:0] lo_bit_q;
	logic [BIT_IDX_W-1:0] hi_bit_q;

	// scan and memory
	logic [WORD_BITS-1:0] mem [MAP_WORDS];
	logic [WI_W:0]        cnt_q;
	logic [WI_W-1:0]      clr_cnt_q;
	logic [WORD_BITS-1:0] rd_data_s1;
	logic [WI_W-1:0]      addr_s1;
	logic                 vld_s1;

	// result
	logic [ADDR_W-1:0] res_addr_q;
	logic              res_status_q;
	out_item_t         out_data_q;
	logic              out_valid_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitmap_bytes_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			bitmap_bytes_q <= cfg_wr_data;
		end
	end

	// transaction capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= in_data.op;
			base_q <= in_data.region_base;
			len_q  <= in_data.region_length;
		end
	end

	// first page and raw stop page
	logic [END_W-1:0]  end_w;
	logic [END_W-1:0]  end_up;
	logic [BASE_W-1:0] base_page;
	logic [BASE_W-1:0] first_calc;
	logic [END_W-1:0]  stop_calc;

	always_comb begin
		end_w     = END_W'(base_q) + END_W'(len_q);
		end_up    = END_W'(base_q) + END_W'(len_q) + END_W'(PAGE_BYTES - 1);
		base_page = base_q >> PAGE_SHIFT;
		first_calc = base_page;
		stop_calc  = '0;
		unique case (op_q)
			OP_ALLOC: begin
				first_calc = '0;
				stop_calc  = END_W'({bitmap_bytes_q, {BYTE_SHIFT{1'b0}}});
			end
			OP_FREE_PAGE:      stop_calc = END_W'(base_page) + END_W'(1);
			OP_FREE_REGION:    stop_calc = end_w >> PAGE_SHIFT;
			OP_RESERVE_REGION: stop_calc = end_up >> PAGE_SHIFT;
			default:           stop_calc = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			first_q    <= first_calc;
			stop_raw_q <= stop_calc;
		end
	end

	// clamp to the store and split into word and bit bounds
	logic [END_W-1:0] stop_cl;
	logic [END_W-1:0] last_page;
	logic             empty_b;

	always_comb begin
		stop_cl   = (stop_raw_q > NUM_PAGES_E) ? NUM_PAGES_E : stop_raw_q;
		empty_b   = END_W'(first_q) >= stop_cl;
		last_page = stop_cl - END_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.bound) begin
			first_word_q <= first_q[PW-1:BIT_IDX_W];
			lo_bit_q     <= first_q[BIT_IDX_W-1:0];
			last_word_q  <= last_page[PW-1:BIT_IDX_W];
			hi_bit_q     <= last_page[BIT_IDX_W-1:0];
		end
	end

	// word read counter
	logic            rd_en;
	logic [WI_W-1:0] rd_addr;

	assign rd_addr = cnt_q[WI_W-1:0];
	assign rd_en   = cmd.scan && (cnt_q <= {1'b0, last_word_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.bound) begin
			cnt_q <= {1'b0, first_q[PW-1:BIT_IDX_W]};
		end else if (rd_en) begin
			cnt_q <= cnt_q + (WI_W + 1)'(1);
		end
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear) begin
			clr_cnt_q <= clr_cnt_q + WI_W'(1);
		end
	end

	// per word evaluation
	logic [BIT_IDX_W-1:0] lo;
	logic [BIT_IDX_W-1:0] hi;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] cand;
	logic [WORD_BITS-1:0] low1;
	logic [BIT_IDX_W-1:0] idx;
	logic                 found;
	logic [WORD_BITS-1:0] new_word;
	logic                 hit;
	logic                 is_alloc;
	logic [PW-1:0]        page;
	logic [FA_W-1:0]      full_addr;

	always_comb begin
		lo   = (addr_s1 == first_word_q) ? lo_bit_q : '0;
		hi   = (addr_s1 == last_word_q) ? hi_bit_q : BIT_IDX_MAX;
		mask = ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (BIT_IDX_MAX - hi));
		cand  = mask & ~rd_data_s1;
		low1  = cand & (~cand + WORD_BITS'(1));
		found = |cand;
		idx   = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (low1[i]) idx = idx | BIT_IDX_W'(i);
		end
		page      = {addr_s1, idx};
		full_addr = FA_W'(page) << PAGE_SHIFT;
		is_alloc  = (op_q == OP_ALLOC);
		hit       = cmd.scan && vld_s1;
		unique case (op_q)
			OP_ALLOC:          new_word = rd_data_s1 | low1;
			OP_FREE_PAGE:      new_word = rd_data_s1 & ~mask;
			OP_FREE_REGION:    new_word = rd_data_s1 & ~mask;
			OP_RESERVE_REGION: new_word = rd_data_s1 | mask;
			default:           new_word = rd_data_s1;
		endcase
	end

	// memory write port: clearing pass or modified word
	logic                 wr_en;
	logic [WI_W-1:0]      wr_addr;
	logic [WORD_BITS-1:0] wr_word;

	always_comb begin
		wr_en   = cmd.clear || (hit && (!is_alloc || found));
		wr_addr = cmd.clear ? clr_cnt_q : addr_s1;
		wr_word = cmd.clear ? {WORD_BITS{1'b1}} : new_word;
	end

	// bitmap memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			addr_s1    <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.bound) begin
			res_addr_q   <= '0;
			res_status_q <= is_alloc;
		end else if (hit && is_alloc && found) begin
			res_addr_q   <= full_addr[ADDR_W-1:0];
			res_status_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.post) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.post) begin
			out_data_q.page_address <= res_addr_q;
			out_data_q.status       <= res_status_q;
		end
	end

	// status to controller
	always_comb begin
		sts.clear_last = (clr_cnt_q == LAST_WORD);
		sts.empty      = empty_b;
		sts.scan_done  = hit && ((is_alloc && found) || (addr_s1 == last_word_q));
		sts.out_free   = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

>>> design/bitmap_page_frame_allocator_unit.sv
// sequence: an accepted transaction passes the calc, bound, scan and post states, the scan
// walking the bitmap words one per cycle; an empty page range skips the scan, and any wait
// for the output register holds post; one transaction at a time, the next taken in idle
// once the result sits in the output register; alloc walks up to 128 words
// reset: async active low; a clearing pass with in_stall high sets every bitmap word, and
// bitmap_bytes comes up as 512
`default_nettype none

module bitmap_page_frame_allocator_unit
	import bpfa_pkg::*;
#(
	parameter int PAGE_BYTES = 4096,
	parameter int NUM_PAGES  = 4096
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CFG_W-1:0] cfg_wr_data,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire in_item_t         in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_item_t             out_data
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	bpfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// bitmap store and word walk
	bpfa_datapath #(
		.PAGE_BYTES (PAGE_BYTES),
		.NUM_PAGES  (NUM_PAGES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.cmd         (cmd),
		.sts         (sts),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_data    (out_data)
	);

endmodule

`default_nettype wire

>>> design/bpfa_checker.sv
`default_nettype none

module bpfa_checker
	import bpfa_pkg::*;
#(
	parameter int PAGE_BYTES = 4096
) (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_item_t out_data
);

	// a failed alloc never carries an address
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status) |-> (out_data.page_address == '0))
		else $error("out of memory result with nonzero address");

	// addresses are page aligned
	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.page_address & ADDR_W'(PAGE_BYTES - 1)) == '0))
		else $error("page address not aligned");

	// one transaction at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again without processing");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");

endmodule

bind bitmap_page_frame_allocator_unit bpfa_checker #(
	.PAGE_BYTES (PAGE_BYTES)
) u_bpfa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
